// ===== design/mf3_pkg.sv =====
package mf3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int PIX_W       = 8;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int N_TAPS      = 9;

  localparam logic [WIDTH_REG_W-1:0]  MIN_WIDTH_CFG  = 11'd3;
  localparam logic [WIDTH_REG_W-1:0]  MAX_WIDTH_CFG  = WIDTH_REG_W'(MAX_WIDTH);
  localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT_CFG = 13'd3;
  localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT_CFG = 13'd4096;
  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH    = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT   = 13'd480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // {min, max}
  function automatic logic [2*PIX_W-1:0] sort2(input pix_t a, input pix_t b);
    sort2 = (a > b) ? {b, a} : {a, b};
  endfunction

endpackage

// ===== design/mf3_median.sv =====
module mf3_median (
  input  logic          clk,
  input  logic          en,
  input  mf3_pkg::pix_t taps [mf3_pkg::N_TAPS],
  output mf3_pkg::pix_t median
);
  import mf3_pkg::*;

  pix_t a [N_TAPS];
  pix_t a_q [N_TAPS];
  pix_t b [N_TAPS];

  // first half: sort each group of three
  always_comb begin
    for (int i = 0; i < N_TAPS; i++) begin
      a[i] = taps[i];
    end
    {a[1], a[2]} = sort2(a[1], a[2]);
    {a[4], a[5]} = sort2(a[4], a[5]);
    {a[7], a[8]} = sort2(a[7], a[8]);
    {a[0], a[1]} = sort2(a[0], a[1]);
    {a[3], a[4]} = sort2(a[3], a[4]);
    {a[6], a[7]} = sort2(a[6], a[7]);
    {a[1], a[2]} = sort2(a[1], a[2]);
    {a[4], a[5]} = sort2(a[4], a[5]);
    {a[7], a[8]} = sort2(a[7], a[8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= a;
    end
  end

  // second half: merge down to the middle element
  always_comb begin
    for (int i = 0; i < N_TAPS; i++) begin
      b[i] = a_q[i];
    end
    {b[0], b[3]} = sort2(b[0], b[3]);
    {b[5], b[8]} = sort2(b[5], b[8]);
    {b[4], b[7]} = sort2(b[4], b[7]);
    {b[3], b[6]} = sort2(b[3], b[6]);
    {b[1], b[4]} = sort2(b[1], b[4]);
    {b[2], b[5]} = sort2(b[2], b[5]);
    {b[4], b[7]} = sort2(b[4], b[7]);
    {b[4], b[2]} = sort2(b[4], b[2]);
    {b[6], b[4]} = sort2(b[6], b[4]);
    {b[4], b[2]} = sort2(b[4], b[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      median <= b[4];
    end
  end

endmodule

// ===== design/median_filter_3x3.sv =====
// 3x3 median filter on a raster stream of 8-bit pixels. One pixel beat is
// taken per clock; the pipeline holds only when the four-entry result queue
// could not absorb two more results. Two results come from a pixel in the last
// column from row 2 on and from every pixel past column 1 of the last row;
// there the output side sets the pace (one result beat per clock while
// result_stall is low), so along the last row the pixel input slows to match.
// A pixel's results pass four steps: line-store read, window/sort stage one,
// sort stage two, queue.
// Both line stores share one 1024 x 16 synchronous RAM, read and written back
// once per pixel. Writing image_width or image_height restarts the frame at
// row 0, column 0; do so only when no results are pending.
module median_filter_3x3 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [mf3_pkg::PIX_W-1:0]           pixel_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [mf3_pkg::ROW_W-1:0]           out_row,
  output logic [mf3_pkg::COL_W-1:0]           out_col,
  output logic [mf3_pkg::PIX_W-1:0]           out_value,
  output logic                                last_of_run,
  output logic                                frame_done
);
  import mf3_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             border;
    logic             done;
  } meta_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             value;
    logic             last;
    logic             done;
  } result_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // configuration
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WIDTH_REG_W-1:0]  w_used;
  logic [HEIGHT_REG_W-1:0] h_used;
  logic [COL_W-1:0]        last_col;
  logic [ROW_W-1:0]        last_row;
  logic [WIDTH_REG_W-1:0]  w_m1;
  logic [HEIGHT_REG_W-1:0] h_m1;

  always_comb begin
    w_used = image_width;
    if (image_width < MIN_WIDTH_CFG) w_used = MIN_WIDTH_CFG;
    if (image_width > MAX_WIDTH_CFG) w_used = MAX_WIDTH_CFG;
    h_used = image_height;
    if (image_height < MIN_HEIGHT_CFG) h_used = MIN_HEIGHT_CFG;
    if (image_height > MAX_HEIGHT_CFG) h_used = MAX_HEIGHT_CFG;
    w_m1     = w_used - 1'b1;
    h_m1     = h_used - 1'b1;
    last_col = w_m1[COL_W-1:0];
    last_row = h_m1[ROW_W-1:0];
  end

  // pipeline control
  logic [QPTR_W:0] q_count;
  logic            advance;
  logic            accept;

  assign advance     = (q_count <= (QPTR_W+1)'(QDEPTH - 2));
  assign pixel_stall = !advance;
  assign accept      = pixel_valid && advance;

  // position counters
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic             at_last_col;
  logic             at_last_row;

  assign at_last_col = (col_count == last_col);
  assign at_last_row = (row_count == last_row);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_count <= '0;
        row_count <= at_last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // line-store RAM: [15:8] upper row, [7:0] middle row
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  // stage 1
  logic             s1_v;
  meta_t            s1_meta;
  pix_t             s1_p;
  pix_t             top;
  pix_t             mid;

  assign top = rd_q[2*PIX_W-1:PIX_W];
  assign mid = rd_q[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= line_mem[col_count];
    end
    if (advance && s1_v) begin
      line_mem[s1_meta.col] <= {mid, s1_p};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (advance) begin
      s1_v <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_p              <= pixel_value;
      s1_meta.row       <= row_count;
      s1_meta.col       <= col_count;
      s1_meta.interior  <= (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
      s1_meta.border    <= (row_count == '0) || (col_count == '0) ||
                           at_last_row || at_last_col;
      s1_meta.done      <= at_last_row && at_last_col;
    end
  end

  // window of the two previous columns
  pix_t win [6];
  pix_t taps [N_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (advance && s1_v) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_p;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      taps[i] = win[i];
    end
    taps[6] = top;
    taps[7] = mid;
    taps[8] = s1_p;
  end

  pix_t median;

  mf3_median u_median (
    .clk    (clk),
    .en     (advance),
    .taps   (taps),
    .median (median)
  );

  // stages 2 and 3 sideband
  logic  s2_v, s3_v;
  meta_t s2_meta, s3_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (advance) begin
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_meta <= s1_meta;
      s3_meta <= s2_meta;
    end
  end

  // result queue
  result_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] q_wr;
  logic [QPTR_W-1:0] q_rd;
  result_t          res_int;
  result_t          res_bdr;
  logic             push0, push1;
  logic             pop;
  logic [QPTR_W:0]  push_n;

  always_comb begin
    res_int.row   = s3_meta.row - 1'b1;
    res_int.col   = s3_meta.col - 1'b1;
    res_int.value = median;
    res_int.last  = !s3_meta.border;
    res_int.done  = 1'b0;
    res_bdr.row   = s3_meta.row;
    res_bdr.col   = s3_meta.col;
    res_bdr.value = '0;
    res_bdr.last  = 1'b1;
    res_bdr.done  = s3_meta.done;
    push0  = advance && s3_v && (s3_meta.interior || s3_meta.border);
    push1  = advance && s3_v && s3_meta.interior && s3_meta.border;
    push_n = (QPTR_W+1)'(push0) + (QPTR_W+1)'(push1);
  end

  assign pop = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (push0) begin
      q_mem[q_wr] <= s3_meta.interior ? res_int : res_bdr;
    end
    if (push1) begin
      q_mem[q_wr + 1'b1] <= res_bdr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      q_wr    <= q_wr + push_n[QPTR_W-1:0];
      q_rd    <= q_rd + QPTR_W'(pop);
      q_count <= q_count + push_n - (QPTR_W+1)'(pop);
    end
  end

  assign result_valid = (q_count != '0);
  assign out_row      = q_mem[q_rd].row;
  assign out_col      = q_mem[q_rd].col;
  assign out_value    = q_mem[q_rd].value;
  assign last_of_run  = q_mem[q_rd].last;
  assign frame_done   = q_mem[q_rd].done;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mf3_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             value;
    logic             last;
    logic             done;
  } out_px_t;

  typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_CLUSTER} pix_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pix_t        pixel_value = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  pix_t        out_value;
  logic        last_of_run;
  logic        frame_done;

  median_filter_3x3 i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_value  (pixel_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

  always #6 clk = ~clk;

  // filter state as seen by the checker
  logic [WIDTH_REG_W-1:0]  width_reg  = RESET_WIDTH;
  logic [HEIGHT_REG_W-1:0] height_reg = RESET_HEIGHT;
  pix_t upper_line  [MAX_WIDTH];
  pix_t middle_line [MAX_WIDTH];
  pix_t win_cols [6];
  int   row_pos = 0;
  int   col_pos = 0;

  pix_t    pixels_to_send [$];
  out_px_t filtered_due [$];
  out_px_t want;

  int gap_max = 17;
  int hold_max = 17;
  int gap_left = 0;
  int hold_left = 0;
  int stall_draw;
  int error_count = 0;
  int pixels_queued = 0;
  int pixels_accepted = 0;

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic int used_width();
    if (width_reg < MIN_WIDTH_CFG) return int'(MIN_WIDTH_CFG);
    if (width_reg > MAX_WIDTH_CFG) return int'(MAX_WIDTH_CFG);
    return int'(width_reg);
  endfunction

  function automatic int used_height();
    if (height_reg < MIN_HEIGHT_CFG) return int'(MIN_HEIGHT_CFG);
    if (height_reg > MAX_HEIGHT_CFG) return int'(MAX_HEIGHT_CFG);
    return int'(height_reg);
  endfunction

  function automatic pix_t median_of9(input logic [8:0][7:0] v);
    logic [8:0][7:0] s;
    pix_t t;
    s = v;
    for (int i = 0; i < 9; i++)
      for (int j = i + 1; j < 9; j++)
        if (s[i] > s[j]) begin
          t = s[i];
          s[i] = s[j];
          s[j] = t;
        end
    return s[4];
  endfunction

  // one pixel beat: update line stores and window, queue 0..2 results
  function automatic void filter_pixel(input pix_t p);
    int w, h, r, c, n;
    pix_t top, mid;
    logic [8:0][7:0] hood;
    out_px_t made [2];
    w = used_width();
    h = used_height();
    r = row_pos;
    c = col_pos;
    n = 0;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = p;
    if (r >= 2 && c >= 2) begin
      hood = {win_cols[0], win_cols[1], win_cols[2], win_cols[3], win_cols[4],
              win_cols[5], top, mid, p};
      made[0].row = ROW_W'(r - 1);
      made[0].col = COL_W'(c - 1);
      made[0].value = median_of9(hood);
      made[0].last = 1'b0;
      made[0].done = 1'b0;
      n = 1;
    end
    for (int i = 0; i < 3; i++) win_cols[i] = win_cols[i + 3];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = p;
    if (r == 0 || c == 0 || r == h - 1 || c == w - 1) begin
      made[n].row = ROW_W'(r);
      made[n].col = COL_W'(c);
      made[n].value = '0;
      made[n].last = 1'b0;
      made[n].done = (r == h - 1 && c == w - 1);
      n++;
    end
    if (n > 0) made[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) filtered_due.push_back(made[i]);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        filter_pixel(pixel_value);
        pixels_accepted++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (gap_left != 0) begin
          pixel_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixels_to_send.size() != 0) begin
          pixel_valid <= 1'b1;
          pixel_value <= pixels_to_send.pop_front();
          gap_left <= $urandom_range(0, gap_max);
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
    end else if (result_valid && !result_stall) begin
      if (filtered_due.size() == 0) begin
        flag_error($sformatf("unexpected result beat row %0d col %0d", out_row, out_col));
      end else begin
        want = filtered_due.pop_front();
        if (out_row !== want.row)
          flag_error($sformatf("out_row %0d, want %0d", out_row, want.row));
        if (out_col !== want.col)
          flag_error($sformatf("out_col %0d, want %0d (row %0d)", out_col, want.col, want.row));
        if (out_value !== want.value)
          flag_error($sformatf("out_value %0d, want %0d at (%0d,%0d)",
                               out_value, want.value, want.row, want.col));
        if (last_of_run !== want.last)
          flag_error($sformatf("last_of_run %b, want %b at (%0d,%0d)",
                               last_of_run, want.last, want.row, want.col));
        if (frame_done !== want.done)
          flag_error($sformatf("frame_done %b, want %b at (%0d,%0d)",
                               frame_done, want.done, want.row, want.col));
      end
      stall_draw = $urandom_range(0, hold_max);
      result_stall <= (stall_draw != 0);
      hold_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic apb_xfer(input logic idx, input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] expv);
    logic [31:0] rd;
    apb_xfer(idx, 1'b0, '0, rd);
    if (rd !== expv) flag_error($sformatf("register %0d reads %0d, want %0d", idx, rd, expv));
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(idx, 1'b1, value, rd);
    if (idx == REG_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
    else height_reg = value[HEIGHT_REG_W-1:0];
    row_pos = 0;
    col_pos = 0;
    if (idx == REG_WIDTH) check_reg(idx, 32'(width_reg));
    else check_reg(idx, 32'(height_reg));
  endtask

  task automatic queue_one(input pix_t p);
    pixels_to_send.push_back(p);
    pixels_queued++;
  endtask

  task automatic queue_pixels(input int n, input pix_style_t style);
    pix_t base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      case (style)
        PIX_EXTREME: queue_one($urandom_range(0, 1) ? 8'hFF : 8'h00);
        PIX_CLUSTER: queue_one(base + 8'($urandom_range(0, 3)));
        default:     queue_one(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // wait until every pixel is taken and every result seen, then let the pipe empty
  task automatic settle();
    while (pixels_accepted != pixels_queued || filtered_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int pick_slack();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 17;
    endcase
  endfunction

  initial begin
    int w, h, n, frame, random_items;
    pix_t frame_a [12];
    pix_t frame_b [9];
    frame_a = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd255, 8'd1, 8'd254, 8'd255,
                8'd7, 8'd8, 8'd9};
    frame_b = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, first row only
    check_reg(REG_WIDTH, 32'(RESET_WIDTH));
    check_reg(REG_HEIGHT, 32'(RESET_HEIGHT));
    queue_pixels(60, PIX_UNIFORM);
    settle();

    // smallest frame, extremes, wrap into next frame, no idling
    gap_max = 0;
    hold_max = 0;
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd3);
    foreach (frame_a[i]) queue_one(frame_a[i]);
    settle();

    // below-range sizes clamp to 3x3
    gap_max = 17;
    hold_max = 17;
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd1);
    foreach (frame_b[i]) queue_one(frame_b[i]);
    settle();

    // widest frame: full first row, into the second
    gap_max = 1;
    hold_max = 1;
    write_reg(REG_WIDTH, 32'd1024);
    write_reg(REG_HEIGHT, 32'd3);
    queue_pixels(1024 + 6, PIX_UNIFORM);
    settle();

    // tallest frame, first rows
    gap_max = 0;
    hold_max = 1;
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd4096);
    queue_pixels(3 * 40 + 4, PIX_UNIFORM);
    settle();

    random_items = 0;
    while (random_items < 600) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(1025, 2047);
        2:       w = $urandom_range(13, 64);
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       h = $urandom_range(0, 2);
        1:       h = $urandom_range(4097, 8191);
        default: h = $urandom_range(3, 8);
      endcase
      if ($urandom_range(0, 4) != 0) write_reg(REG_WIDTH, 32'(w));
      if ($urandom_range(0, 4) != 0) write_reg(REG_HEIGHT, 32'(h));
      frame = used_width() * used_height();
      if (used_width() > 64) n = $urandom_range(20, 80);
      else if (used_width() > 12 || used_height() > 8) n = $urandom_range(1, 4 * used_width());
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, frame);
      else n = frame * $urandom_range(1, 2) + $urandom_range(0, frame);
      gap_max = pick_slack();
      hold_max = pick_slack();
      case ($urandom_range(0, 5))
        0:       queue_pixels(n, PIX_EXTREME);
        1:       queue_pixels(n, PIX_CLUSTER);
        default: queue_pixels(n, PIX_UNIFORM);
      endcase
      random_items += n;
      settle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0 && filtered_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
